// File: rtl/core/hsrm_pkg.sv
package hsrm_pkg;

    // Fixed-point scaling of the two reciprocal tables
    localparam int unsigned HSV_SHIFT     = 12;
    localparam int unsigned HSV_HALF      = 2048;
    localparam int unsigned SAT_SCALE_NUM = 1044480;
    localparam int unsigned HUE_SCALE_NUM = 122880;
    localparam int unsigned HUE_RANGE     = 180;
    localparam int unsigned SAT_MAX       = 255;

    // Field widths
    localparam int unsigned PIX_W   = 8;
    localparam int unsigned X_W     = 12;
    localparam int unsigned SDIV_W  = 20;
    localparam int unsigned HDIV_W  = 17;
    localparam int unsigned SPROD_W = 22;
    localparam int unsigned HPROD_W = 22;
    localparam int unsigned ADDR_W  = 4;

    // Register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_MIN_HUE = 2'd0;
    localparam logic [1:0] REG_MAX_HUE = 2'd1;
    localparam logic [1:0] REG_MIN_SAT = 2'd2;
    localparam logic [1:0] REG_MAX_SAT = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0]        v;
        logic [PIX_W-1:0]        diff;
        logic signed [X_W-1:0]   x;
    } minmax_t;

    typedef struct packed {
        logic [PIX_W-1:0]        diff;
        logic signed [X_W-1:0]   x;
        logic [SDIV_W-1:0]       sdiv;
        logic [HDIV_W-1:0]       hdiv;
    } recip_t;

    typedef struct packed {
        logic [SPROD_W-1:0]        sprod;
        logic signed [HPROD_W-1:0] hprod;
    } prod_t;

    typedef struct packed {
        logic             in_range;
        logic [PIX_W-1:0] hue;
        logic [PIX_W-1:0] saturation;
    } result_t;

    typedef struct packed {
        logic [PIX_W-1:0] min_hue;
        logic [PIX_W-1:0] max_hue;
        logic [PIX_W-1:0] min_sat;
        logic [PIX_W-1:0] max_sat;
    } cfg_t;

endpackage

// File: rtl/core/hue_saturation_range_mask_unit.sv
// Channel    Dir  Port group           Contents (lowest bit first)
// pixel in   in   s_tvalid/s_tready    s_tdata: blue[7:0] green[15:8] red[23:16]
// result     out  m_tvalid/m_tready    m_tdata: hue[7:0] saturation[15:8];
//                                      m_tuser: in_range
// config     in   APB psel/penable     min_hue 0x0, max_hue 0x4, min_sat 0x8, max_sat 0xC
//
// One pixel word enters per clock while no stall holds the pipeline; each result
// passes through the four register stages: min/max, reciprocal tables,
// multipliers, rounding and window compare.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// register defaults. A stall holds every full stage in place; empty stages
// still fill, so bubbles are squeezed out.
module hue_saturation_range_mask_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // pixel input
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // blue, green, red
    // result output
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [15:0]                   m_tdata,   // hue, saturation
    output logic [0:0]                    m_tuser,   // in_range
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hsrm_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    hsrm_pkg::cfg_t     cfg_reg;
    hsrm_pkg::pixel_t   pix;
    hsrm_pkg::minmax_t  mm_data;
    hsrm_pkg::recip_t   rc_data;
    hsrm_pkg::prod_t    pr_data;
    hsrm_pkg::result_t  res_data;
    logic               mm_valid;
    logic               mm_ready;
    logic               rc_valid;
    logic               rc_ready;
    logic               pr_valid;
    logic               pr_ready;
    logic               wr_en;
    logic [1:0]         reg_idx;

    // Register file
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_hue <= 8'd0;
            cfg_reg.max_hue <= 8'd179;
            cfg_reg.min_sat <= 8'd0;
            cfg_reg.max_sat <= 8'd255;
        end else if (wr_en) begin
            unique case (reg_idx)
                hsrm_pkg::REG_MIN_HUE: cfg_reg.min_hue <= pwdata[7:0];
                hsrm_pkg::REG_MAX_HUE: cfg_reg.max_hue <= pwdata[7:0];
                hsrm_pkg::REG_MIN_SAT: cfg_reg.min_sat <= pwdata[7:0];
                hsrm_pkg::REG_MAX_SAT: cfg_reg.max_sat <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_idx)
            hsrm_pkg::REG_MIN_HUE: prdata = {24'd0, cfg_reg.min_hue};
            hsrm_pkg::REG_MAX_HUE: prdata = {24'd0, cfg_reg.max_hue};
            hsrm_pkg::REG_MIN_SAT: prdata = {24'd0, cfg_reg.min_sat};
            hsrm_pkg::REG_MAX_SAT: prdata = {24'd0, cfg_reg.max_sat};
            default:               prdata = '0;
        endcase
    end

    // Unpack the pixel word
    assign pix.blue  = s_tdata[7:0];
    assign pix.green = s_tdata[15:8];
    assign pix.red   = s_tdata[23:16];

    hsrm_minmax u_minmax (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (pix),
        .out_valid (mm_valid),
        .out_ready (mm_ready),
        .out_data  (mm_data)
    );

    hsrm_recip u_recip (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mm_valid),
        .in_ready  (mm_ready),
        .in_data   (mm_data),
        .out_valid (rc_valid),
        .out_ready (rc_ready),
        .out_data  (rc_data)
    );

    hsrm_mult u_mult (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rc_valid),
        .in_ready  (rc_ready),
        .in_data   (rc_data),
        .out_valid (pr_valid),
        .out_ready (pr_ready),
        .out_data  (pr_data)
    );

    hsrm_thresh u_thresh (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (pr_valid),
        .in_ready  (pr_ready),
        .in_data   (pr_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_data)
    );

    // Pack the result word
    assign m_tdata = {res_data.saturation, res_data.hue};
    assign m_tuser = res_data.in_range;

`ifndef SYNTH
    // Hue never leaves one turn (below 180)
    a_hue_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] < 8'd180))
        else $error("hue out of range");

    // A passing pixel respects the saturation window
    a_sat_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
        ((m_tdata[15:8] > cfg_reg.min_sat) && (m_tdata[15:8] <= cfg_reg.max_sat)))
        else $error("in_range set outside saturation window");

    // Input back-pressure only when the whole pipeline is full and stalled
    a_stall_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && mm_valid && rc_valid && pr_valid))
        else $error("input stalled with a free stage");

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");
`endif

endmodule

// File: rtl/core/hsrm_minmax.sv
module hsrm_minmax (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  hsrm_pkg::pixel_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hsrm_pkg::minmax_t  out_data
);

    logic                               valid_reg;
    hsrm_pkg::minmax_t                  data_reg;
    hsrm_pkg::minmax_t                  data_next;
    logic [hsrm_pkg::PIX_W-1:0]         v_max;
    logic [hsrm_pkg::PIX_W-1:0]         v_min;
    logic [hsrm_pkg::PIX_W-1:0]         diff;
    logic signed [hsrm_pkg::X_W-1:0]    bs;
    logic signed [hsrm_pkg::X_W-1:0]    gs;
    logic signed [hsrm_pkg::X_W-1:0]    rs;
    logic signed [hsrm_pkg::X_W-1:0]    ds;

    // Largest and smallest channel, and the sector numerator
    always_comb begin
        v_max = in_data.blue;
        v_min = in_data.blue;
        if (in_data.green > v_max) v_max = in_data.green;
        if (in_data.red > v_max) v_max = in_data.red;
        if (in_data.green < v_min) v_min = in_data.green;
        if (in_data.red < v_min) v_min = in_data.red;
        diff = v_max - v_min;
        bs = $signed({4'd0, in_data.blue});
        gs = $signed({4'd0, in_data.green});
        rs = $signed({4'd0, in_data.red});
        ds = $signed({4'd0, diff});
        data_next.v    = v_max;
        data_next.diff = diff;
        if (v_max == in_data.red) begin
            data_next.x = gs - bs;
        end else if (v_max == in_data.green) begin
            data_next.x = bs - rs + (ds <<< 1);
        end else begin
            data_next.x = rs - gs + (ds <<< 2);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Advance when the next stage takes the word or this one is empty
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/core/hsrm_recip.sv
module hsrm_recip (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  hsrm_pkg::minmax_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hsrm_pkg::recip_t   out_data
);

    localparam int unsigned Depth = 1 << hsrm_pkg::PIX_W;

    logic [hsrm_pkg::SDIV_W-1:0] sdiv_rom [Depth];
    logic [hsrm_pkg::HDIV_W-1:0] hdiv_rom [Depth];
    logic                        valid_reg;
    hsrm_pkg::recip_t            data_reg;
    hsrm_pkg::recip_t            data_next;

    // Reciprocal tables, rounded to nearest; a zero divisor reads as zero
    assign sdiv_rom[0] = '0;
    assign hdiv_rom[0] = '0;
    for (genvar i = 1; i < Depth; i++) begin : g_rom
        localparam int unsigned SdivVal = (2 * hsrm_pkg::SAT_SCALE_NUM + i) / (2 * i);
        localparam int unsigned HdivVal = (2 * hsrm_pkg::HUE_SCALE_NUM + i) / (2 * i);
        assign sdiv_rom[i] = hsrm_pkg::SDIV_W'(SdivVal);
        assign hdiv_rom[i] = hsrm_pkg::HDIV_W'(HdivVal);
    end

    always_comb begin
        data_next.diff = in_data.diff;
        data_next.x    = in_data.x;
        data_next.sdiv = sdiv_rom[in_data.v];
        data_next.hdiv = hdiv_rom[in_data.diff];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/core/hsrm_mult.sv
module hsrm_mult (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  hsrm_pkg::recip_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hsrm_pkg::prod_t    out_data
);

    localparam int unsigned SFullW = hsrm_pkg::PIX_W + hsrm_pkg::SDIV_W;
    localparam int unsigned HFullW = hsrm_pkg::X_W + hsrm_pkg::HDIV_W + 1;

    logic                          valid_reg;
    hsrm_pkg::prod_t               data_reg;
    hsrm_pkg::prod_t               data_next;
    logic [SFullW-1:0]             s_full;
    logic signed [HFullW-1:0]      h_full;

    // Scale the difference by the reciprocal of the largest channel, the sector numerator by that of the difference
    always_comb begin
        s_full = SFullW'(in_data.diff) * SFullW'(in_data.sdiv);
        h_full = HFullW'(in_data.x) * $signed({1'b0, in_data.hdiv});
        data_next.sprod = s_full[hsrm_pkg::SPROD_W-1:0];
        data_next.hprod = h_full[hsrm_pkg::HPROD_W-1:0];
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: rtl/core/hsrm_thresh.sv
module hsrm_thresh (
    input  logic               aclk,
    input  logic               aresetn,
    input  hsrm_pkg::cfg_t     cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  hsrm_pkg::prod_t    in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output hsrm_pkg::result_t  out_data
);

    localparam int unsigned HW = hsrm_pkg::HPROD_W - hsrm_pkg::HSV_SHIFT;
    localparam int unsigned SW = hsrm_pkg::SPROD_W - hsrm_pkg::HSV_SHIFT;

    logic                                valid_reg;
    hsrm_pkg::result_t                   data_reg;
    hsrm_pkg::result_t                   data_next;
    logic signed [hsrm_pkg::HPROD_W-1:0] h_sum;
    logic [hsrm_pkg::SPROD_W-1:0]        s_sum;
    logic signed [HW-1:0]                h_raw;
    logic signed [HW-1:0]                h_up;
    logic signed [HW-1:0]                h_wrap;
    logic [SW-1:0]                       s_raw;
    logic                                hue_ok;
    logic                                sat_ok;
    logic                                below_max;
    logic                                above_min;

    // Round, fold hue into one turn, clip saturation, then test both windows
    always_comb begin
        h_sum  = in_data.hprod + hsrm_pkg::HPROD_W'(hsrm_pkg::HSV_HALF);
        s_sum  = in_data.sprod + hsrm_pkg::SPROD_W'(hsrm_pkg::HSV_HALF);
        h_raw  = h_sum[hsrm_pkg::HPROD_W-1:hsrm_pkg::HSV_SHIFT];
        s_raw  = s_sum[hsrm_pkg::SPROD_W-1:hsrm_pkg::HSV_SHIFT];
        h_up   = (h_raw < 0) ? h_raw + HW'(hsrm_pkg::HUE_RANGE) : h_raw;
        h_wrap = (h_up >= $signed(HW'(hsrm_pkg::HUE_RANGE)))
                 ? h_up - HW'(hsrm_pkg::HUE_RANGE) : h_up;
        if (h_wrap < 0) h_wrap = '0;
        data_next.hue        = h_wrap[hsrm_pkg::PIX_W-1:0];
        data_next.saturation = (s_raw > SW'(hsrm_pkg::SAT_MAX))
                               ? hsrm_pkg::PIX_W'(hsrm_pkg::SAT_MAX)
                               : s_raw[hsrm_pkg::PIX_W-1:0];
        below_max = data_next.hue <= cfg.max_hue;
        above_min = data_next.hue > cfg.min_hue;
        if (cfg.min_hue < cfg.max_hue) begin
            hue_ok = below_max && above_min;
        end else begin
            hue_ok = below_max || above_min;
        end
        sat_ok = (data_next.saturation <= cfg.max_sat)
                 && (data_next.saturation > cfg.min_sat);
        data_next.in_range = hue_ok && sat_ok;
    end

    assign in_ready = !valid_reg || out_ready;

    // Output register: hold the word until the sink takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: tb/tb_hue_saturation_range_mask_unit.sv
module tb_hue_saturation_range_mask_unit;

    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned PHASE_WORDS    = 62;
    localparam int unsigned NUM_PHASES     = 7;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [23:0]                   s_tdata  = '0;   // blue, green, red
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [15:0]                   m_tdata;         // hue, saturation
    logic [0:0]                    m_tuser;         // in_range
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [hsrm_pkg::ADDR_W-1:0]   paddr    = '0;
    logic [31:0]                   pwdata   = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    // pixels waiting to be sent, results waiting to arrive
    hsrm_pkg::pixel_t  pixel_q[$];
    hsrm_pkg::result_t hsv_want_q[$];

    // window registers as the block should hold them
    hsrm_pkg::cfg_t cfg_shadow = '{min_hue: 8'd0, max_hue: 8'd179,
                                   min_sat: 8'd0, max_sat: 8'd255};

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned err_count      = 0;
    int unsigned idle_count     = 0;

    // idling modes: none, sender gaps, receiver stalls, both
    int unsigned send_pct_tab [4] = '{0, 45, 0, 13};
    int unsigned recv_pct_tab [4] = '{0, 0, 45, 13};

    // window settings per random phase; the last one is drawn at random
    hsrm_pkg::cfg_t phase_cfg [NUM_PHASES-1] = '{
        '{min_hue: 8'd20,  max_hue: 8'd60,  min_sat: 8'd50,  max_sat: 8'd200},
        '{min_hue: 8'd160, max_hue: 8'd20,  min_sat: 8'd0,   max_sat: 8'd255},
        '{min_hue: 8'd0,   max_hue: 8'd0,   min_sat: 8'd0,   max_sat: 8'd255},
        '{min_hue: 8'd255, max_hue: 8'd255, min_sat: 8'd255, max_sat: 8'd0},
        '{min_hue: 8'd90,  max_hue: 8'd179, min_sat: 8'd0,   max_sat: 8'd128},
        '{min_hue: 8'd179, max_hue: 8'd90,  min_sat: 8'd30,  max_sat: 8'd255}
    };

    // directed pixels: black, white, gray, primaries, channel ties,
    // red largest with green below blue, tiny and alternating values
    hsrm_pkg::pixel_t dir_pix [18] = '{
        '{blue: 8'd0,   green: 8'd0,   red: 8'd0},
        '{blue: 8'd255, green: 8'd255, red: 8'd255},
        '{blue: 8'd128, green: 8'd128, red: 8'd128},
        '{blue: 8'd0,   green: 8'd0,   red: 8'd255},
        '{blue: 8'd0,   green: 8'd255, red: 8'd0},
        '{blue: 8'd255, green: 8'd0,   red: 8'd0},
        '{blue: 8'd0,   green: 8'd255, red: 8'd255},
        '{blue: 8'd200, green: 8'd200, red: 8'd10},
        '{blue: 8'd200, green: 8'd10,  red: 8'd200},
        '{blue: 8'd1,   green: 8'd0,   red: 8'd255},
        '{blue: 8'd40,  green: 8'd0,   red: 8'd255},
        '{blue: 8'd101, green: 8'd100, red: 8'd200},
        '{blue: 8'd0,   green: 8'd0,   red: 8'd1},
        '{blue: 8'd1,   green: 8'd0,   red: 8'd0},
        '{blue: 8'd255, green: 8'd254, red: 8'd0},
        '{blue: 8'd170, green: 8'd85,  red: 8'd240},
        '{blue: 8'd85,  green: 8'd170, red: 8'd15},
        '{blue: 8'd254, green: 8'd255, red: 8'd253}
    };

    hue_saturation_range_mask_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    // BGR to HSV conversion and window test
    function automatic hsrm_pkg::result_t predict_hsv(hsrm_pkg::pixel_t px,
                                                      hsrm_pkg::cfg_t c);
        int                b, g, r, v, mn, diff, x;
        int unsigned       sdiv, hdiv, s;
        longint            h;
        logic [7:0]        hu;
        logic              hue_ok, sat_ok;
        hsrm_pkg::result_t res;
        b = int'(px.blue);
        g = int'(px.green);
        r = int'(px.red);
        v = b;
        mn = b;
        if (g > v) v = g;
        if (r > v) v = r;
        if (g < mn) mn = g;
        if (r < mn) mn = r;
        diff = v - mn;

        // saturation through a rounded reciprocal of the largest channel
        sdiv = (v == 0) ? 0 : (2 * hsrm_pkg::SAT_SCALE_NUM + v) / (2 * v);
        s = (diff * sdiv + hsrm_pkg::HSV_HALF) >> hsrm_pkg::HSV_SHIFT;
        if (s > hsrm_pkg::SAT_MAX) s = hsrm_pkg::SAT_MAX;

        // hue sector: red wins ties over green, green over blue
        if (v == r)
            x = g - b;
        else if (v == g)
            x = b - r + 2 * diff;
        else
            x = r - g + 4 * diff;
        hdiv = (diff == 0) ? 0 : (2 * hsrm_pkg::HUE_SCALE_NUM + diff) / (2 * diff);
        h = (longint'(x) * longint'(hdiv) + longint'(hsrm_pkg::HSV_HALF))
            >>> hsrm_pkg::HSV_SHIFT;
        if (h < 0) h = h + longint'(hsrm_pkg::HUE_RANGE);
        if (h >= longint'(hsrm_pkg::HUE_RANGE)) h = h - longint'(hsrm_pkg::HUE_RANGE);
        if (h < 0) h = 0;
        hu = h[7:0];

        // the hue window wraps through zero when its bounds cross
        if (c.min_hue < c.max_hue)
            hue_ok = (hu <= c.max_hue) && (hu > c.min_hue);
        else
            hue_ok = (hu <= c.max_hue) || (hu > c.min_hue);
        sat_ok = (s[7:0] <= c.max_sat) && (s[7:0] > c.min_sat);

        res.in_range   = hue_ok && sat_ok;
        res.hue        = hu;
        res.saturation = s[7:0];
        return res;
    endfunction

    function automatic hsrm_pkg::pixel_t rand_pixel();
        hsrm_pkg::pixel_t px;
        int unsigned      sel;
        px.blue  = 8'($urandom_range(255));
        px.green = 8'($urandom_range(255));
        px.red   = 8'($urandom_range(255));
        sel = $urandom_range(9);
        // bias towards gray pixels, channel ties and saturated channels
        case (sel)
            0: begin
                px.green = px.blue;
                px.red   = px.blue;
            end
            1: px.red = px.green;
            2: px.green = px.blue;
            3: px.red = px.blue;
            4: begin
                px.red  = 8'd255;
                px.blue = 8'd0;
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: %s mismatch, got %0d want %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            hsrm_pkg::REG_MIN_HUE: cfg_shadow.min_hue = val;
            hsrm_pkg::REG_MAX_HUE: cfg_shadow.max_hue = val;
            hsrm_pkg::REG_MIN_SAT: cfg_shadow.min_sat = val;
            hsrm_pkg::REG_MAX_SAT: cfg_shadow.max_sat = val;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pixel_q.size() != 0 || s_tvalid || hsv_want_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // pixel driver: advance on acceptance, insert gaps at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                hsrm_pkg::pixel_t px;
                px = pixel_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {px.red, px.green, px.blue};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: stall at random
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: predict on each accepted pixel, check each accepted result
    always @(posedge aclk) begin : monitor
        hsrm_pkg::pixel_t  px;
        hsrm_pkg::result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                px = '{blue: s_tdata[7:0], green: s_tdata[15:8], red: s_tdata[23:16]};
                hsv_want_q.push_back(predict_hsv(px, cfg_shadow));
            end
            if (m_tvalid && m_tready) begin
                if (hsv_want_q.size() == 0) begin
                    report_mismatch("unexpected word", 32'(m_tdata), 0);
                end else begin
                    want = hsv_want_q.pop_front();
                    if (m_tuser[0] !== want.in_range)
                        report_mismatch("in_range", 32'(m_tuser[0]), 32'(want.in_range));
                    if (m_tdata[7:0] !== want.hue)
                        report_mismatch("hue", 32'(m_tdata[7:0]), 32'(want.hue));
                    if (m_tdata[15:8] !== want.saturation)
                        report_mismatch("saturation", 32'(m_tdata[15:8]),
                                        32'(want.saturation));
                end
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_count <= 0;
            end else if (idle_count >= WATCHDOG_LIMIT) begin
                $display("tb_hue_saturation_range_mask_unit: done, errors");
                $finish;
            end else begin
                idle_count <= idle_count + 1;
            end
        end
    end

    initial begin : stimulus
        hsrm_pkg::cfg_t c;
        int unsigned    mode;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed pixels under the reset windows, no idling
        foreach (dir_pix[i])
            pixel_q.push_back(dir_pix[i]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_drained();
            if (p < NUM_PHASES - 1) begin
                c = phase_cfg[p];
            end else begin
                c.min_hue = 8'($urandom_range(255));
                c.max_hue = 8'($urandom_range(255));
                c.min_sat = 8'($urandom_range(255));
                c.max_sat = 8'($urandom_range(255));
            end
            write_reg(hsrm_pkg::REG_MIN_HUE, c.min_hue);
            write_reg(hsrm_pkg::REG_MAX_HUE, c.max_hue);
            write_reg(hsrm_pkg::REG_MIN_SAT, c.min_sat);
            write_reg(hsrm_pkg::REG_MAX_SAT, c.max_sat);
            mode = 32'(p % 4);
            send_idle_pct  = send_pct_tab[mode];
            recv_stall_pct = recv_pct_tab[mode];
            for (int n = 0; n < PHASE_WORDS; n++)
                pixel_q.push_back(rand_pixel());
        end

        wait_drained();
        if (err_count == 0)
            $display("tb_hue_saturation_range_mask_unit: done, clean");
        else
            $display("tb_hue_saturation_range_mask_unit: done, errors");
        $finish;
    end

endmodule
